@@ design/mbru_pkg.sv @@
// Shared types, field widths, codes and angle constants for the marker bearing and range unit.
package mbru_pkg;

    localparam int MARKER_W   = 2;
    localparam int RECT_W     = 12;
    localparam int ANGLE_W    = 9;
    localparam int BEAR_W     = 10;
    localparam int DIST_W     = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [MARKER_W-1:0] MK_FRONT  = 2'd0;
    localparam logic [MARKER_W-1:0] MK_REAR   = 2'd1;
    localparam logic [MARKER_W-1:0] MK_TARGET = 2'd2;
    localparam logic [MARKER_W-1:0] MK_HOME   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TOL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_TOL  = 1'd1;

    localparam logic [ANGLE_W-1:0] ANGLE_TOL_RESET = 9'd5;
    localparam logic [DIST_W-1:0]  DIST_TOL_RESET  = 13'd20;
    localparam logic [DIST_W-1:0]  DIST_MAX        = 13'h1FFF;

    localparam int PRESHIFT = 16;
    localparam int ITER_W   = 4;
    localparam logic [ITER_W-1:0] ITER_LAST = 4'd15;

    localparam int ZW = 26;
    typedef logic signed [ZW-1:0] t_z;

    localparam t_z DEG_1   = 26'sd65536;
    localparam t_z DEG_45  = 26'sd2949120;
    localparam t_z DEG_90  = 26'sd5898240;
    localparam t_z DEG_180 = 26'sd11796480;
    localparam t_z DEG_360 = 26'sd23592960;

    typedef enum logic [1:0] {
        JOB_HEADING = 2'd0,
        JOB_TARGET  = 2'd1,
        JOB_HOME    = 2'd2
    } t_job;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_LOAD = 10'b00_0000_0010,
        S_PREP = 10'b00_0000_0100,
        S_ROT  = 10'b00_0000_1000,
        S_OCT  = 10'b00_0001_0000,
        S_QUAD = 10'b00_0010_0000,
        S_SQX  = 10'b00_0100_0000,
        S_SQY  = 10'b00_1000_0000,
        S_ROOT = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } t_state;

    // Arctangent of 2^-i in units of 2^-16 degree.
    function automatic t_z atan_q16(input logic [ITER_W-1:0] idx);
        t_z v;
        unique case (idx)
            4'd0:  v = 26'sd2949120;
            4'd1:  v = 26'sd1740967;
            4'd2:  v = 26'sd919879;
            4'd3:  v = 26'sd466945;
            4'd4:  v = 26'sd234379;
            4'd5:  v = 26'sd117304;
            4'd6:  v = 26'sd58666;
            4'd7:  v = 26'sd29335;
            4'd8:  v = 26'sd14668;
            4'd9:  v = 26'sd7334;
            4'd10: v = 26'sd3667;
            4'd11: v = 26'sd1833;
            4'd12: v = 26'sd917;
            4'd13: v = 26'sd458;
            4'd14: v = 26'sd229;
            4'd15: v = 26'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ design/marker_bearing_range_unit.sv @@
// Marker bearing and range unit: stores marker centers and, on home, computes heading,
// bearings, distances and tolerance flags with a shared vectoring CORDIC and root unit.
//
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+-----------------------------------------
//   request   | in        | i_valid / o_stall  | i_marker, i_rect_x/y, i_rect_width/height
//   result    | out       | o_valid / i_stall  | o_heading, bearings, distances, flags
//   config    | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
// Front, rear and target requests are stored as they are taken and leave the unit idle.
// A home request runs three angle passes (setup in S_LOAD and S_PREP, up to 16 CORDIC steps,
// unfold in S_OCT and S_QUAD) and two root passes (squares in S_SQX and S_SQY, COORD_BITS+1
// root steps), then loads the result from S_DONE into the output register.
// Reset is synchronous and active low; it clears the stored centers and sets the tolerances to their reset values.
// A stalled result holds in the output register; front, rear and target requests are
// still taken meanwhile, and a new home result waits until the register is free.
module marker_bearing_range_unit
    import mbru_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [MARKER_W-1:0]           i_marker,
    input  logic [RECT_W-1:0]             i_rect_x,
    input  logic [RECT_W-1:0]             i_rect_y,
    input  logic [RECT_W-1:0]             i_rect_width,
    input  logic [RECT_W-1:0]             i_rect_height,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ANGLE_W-1:0]            o_heading,
    output logic signed [BEAR_W-1:0]      o_target_bearing,
    output logic [DIST_W-1:0]             o_target_distance,
    output logic signed [BEAR_W-1:0]      o_home_bearing,
    output logic [DIST_W-1:0]             o_home_distance,
    output logic                          o_target_angle_off,
    output logic                          o_target_far,
    output logic                          o_home_angle_off,
    output logic                          o_home_far,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int CB = COORD_BITS;
    localparam int VW = CB + 1;
    localparam int XW = CB + PRESHIFT + 3;
    localparam int NW = 2 * CB + 2;
    localparam int RW = CB + 1;
    localparam int EW = ((CB > RECT_W + 1) ? CB : RECT_W + 1) + 1;
    localparam int LW = ((RW > DIST_W) ? RW : DIST_W) + 1;

    t_state                 r_state;
    t_job                   r_job;
    logic [ITER_W-1:0]      r_iter;
    logic [CB-1:0]          r_cx [3];
    logic [CB-1:0]          r_cy [3];
    logic [CB-1:0]          r_hx, r_hy, r_bx, r_by;
    logic                   r_ax_neg, r_ay_neg;
    logic [CB-1:0]          r_u, r_v;
    logic                   r_swap, r_zero, r_b0, r_beq;
    logic signed [XW-1:0]   r_x, r_y;
    t_z                     r_z, r_t;
    logic [ANGLE_W-1:0]     r_heading, r_ang_t, r_ang_h;
    logic [DIST_W-1:0]      r_dist_t, r_dist_h;
    logic [NW-1:0]          r_n, r_root, r_bit;
    logic [ANGLE_W-1:0]     r_ang_tol;
    logic [DIST_W-1:0]      r_dist_tol;
    logic                   r_out_valid;
    logic [ANGLE_W-1:0]     r_o_heading;
    logic signed [BEAR_W-1:0] r_o_tb, r_o_hb;
    logic [DIST_W-1:0]      r_o_td, r_o_hd;
    logic                   r_o_tao, r_o_tf, r_o_hao, r_o_hf;

    logic                   acc_in;
    logic [EW-1:0]          sum_x, sum_y, cmax;
    logic [CB-1:0]          cx, cy;
    logic [CB:0]            mid_x, mid_y;
    logic [CB-1:0]          min_x, min_y, sub_x, sub_y;
    logic signed [VW-1:0]   vec_x, vec_y, abs_x, abs_y;
    logic                   swap;
    logic [CB-1:0]          oct_a, oct_b;
    logic signed [XW-1:0]   xs, ys;
    t_z                     t_oct, t_fold, phi;
    logic [ANGLE_W-1:0]     angle;
    logic [CB-1:0]          mul_op;
    logic [2*CB-1:0]        sq;
    logic [NW-1:0]          trial, n_n, n_root;
    logic [LW-1:0]          root_ext;
    logic [DIST_W-1:0]      root_dist;
    logic signed [BEAR_W-1:0] tb, hb, atb, ahb;
    logic                   out_load;

    assign o_stall = (r_state != S_IDLE);
    assign acc_in  = i_valid && (r_state == S_IDLE);

    // Rectangle center, saturated to the coordinate range.
    assign cmax  = {{(EW - CB){1'b0}}, {CB{1'b1}}};
    assign sum_x = EW'(i_rect_x) + EW'(i_rect_width[RECT_W-1:1]);
    assign sum_y = EW'(i_rect_y) + EW'(i_rect_height[RECT_W-1:1]);
    assign cx    = (sum_x > cmax) ? {CB{1'b1}} : sum_x[CB-1:0];
    assign cy    = (sum_y > cmax) ? {CB{1'b1}} : sum_y[CB-1:0];

    assign mid_x = {1'b0, r_cx[MK_FRONT]} + {1'b0, r_cx[MK_REAR]};
    assign mid_y = {1'b0, r_cy[MK_FRONT]} + {1'b0, r_cy[MK_REAR]};

    always_comb begin
        unique case (r_job)
            JOB_HEADING: begin
                min_x = r_cx[MK_FRONT];
                min_y = r_cy[MK_FRONT];
                sub_x = r_cx[MK_REAR];
                sub_y = r_cy[MK_REAR];
            end
            JOB_TARGET: begin
                min_x = r_cx[MK_TARGET];
                min_y = r_cy[MK_TARGET];
                sub_x = r_bx;
                sub_y = r_by;
            end
            JOB_HOME: begin
                min_x = r_hx;
                min_y = r_hy;
                sub_x = r_bx;
                sub_y = r_by;
            end
            default: begin
                min_x = '0;
                min_y = '0;
                sub_x = '0;
                sub_y = '0;
            end
        endcase
    end

    assign vec_x = $signed({1'b0, min_x}) - $signed({1'b0, sub_x});
    assign vec_y = $signed({1'b0, min_y}) - $signed({1'b0, sub_y});
    assign abs_x = vec_x[VW-1] ? -vec_x : vec_x;
    assign abs_y = vec_y[VW-1] ? -vec_y : vec_y;

    assign swap  = (r_v > r_u);
    assign oct_a = swap ? r_v : r_u;
    assign oct_b = swap ? r_u : r_v;

    assign xs = r_x >>> r_iter;
    assign ys = r_y >>> r_iter;

    always_comb begin
        priority if (r_b0) begin
            t_oct = '0;
        end else if (r_beq) begin
            t_oct = DEG_45;
        end else if (r_z < DEG_1 - DEG_1 + t_z'(1)) begin
            t_oct = t_z'(1);
        end else if (r_z > DEG_45 - t_z'(1)) begin
            t_oct = DEG_45 - t_z'(1);
        end else begin
            t_oct = r_z;
        end
        t_fold = r_swap ? (DEG_90 - t_oct) : t_oct;
    end

    always_comb begin
        priority if (!r_ay_neg && !r_ax_neg) begin
            phi = r_t;
        end else if (r_ay_neg && !r_ax_neg) begin
            phi = DEG_180 - r_t;
        end else if (r_ay_neg) begin
            phi = DEG_180 + r_t;
        end else begin
            phi = DEG_360 - r_t;
        end
        angle = r_zero ? '0 : phi[PRESHIFT+ANGLE_W-1:PRESHIFT];
    end

    assign mul_op = (r_state == S_SQX) ? r_u : r_v;
    assign sq     = mul_op * mul_op;

    assign trial     = r_root + r_bit;
    assign n_n       = (r_n >= trial) ? (r_n - trial) : r_n;
    assign n_root    = (r_n >= trial) ? ((r_root >> 1) + r_bit) : (r_root >> 1);
    assign root_ext  = LW'(n_root[RW-1:0]);
    assign root_dist = (root_ext > LW'(DIST_MAX)) ? DIST_MAX : root_ext[DIST_W-1:0];

    assign tb  = $signed({1'b0, r_ang_t}) - $signed({1'b0, r_heading});
    assign hb  = $signed({1'b0, r_ang_h}) - $signed({1'b0, r_heading});
    assign atb = tb[BEAR_W-1] ? -tb : tb;
    assign ahb = hb[BEAR_W-1] ? -hb : hb;

    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job       <= JOB_HEADING;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
            r_ang_tol   <= ANGLE_TOL_RESET;
            r_dist_tol  <= DIST_TOL_RESET;
            for (int i = 0; i < 3; i++) begin
                r_cx[i] <= '0;
                r_cy[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ANGLE_TOL: r_ang_tol  <= i_cfg_data[ANGLE_W-1:0];
                    REG_DIST_TOL:  r_dist_tol <= i_cfg_data[DIST_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        if (i_marker == MK_HOME) begin
                            r_job   <= JOB_HEADING;
                            r_state <= S_LOAD;
                        end else begin
                            r_cx[i_marker] <= cx;
                            r_cy[i_marker] <= cy;
                        end
                    end
                end
                S_LOAD: r_state <= S_PREP;
                S_PREP: begin
                    r_iter <= '0;
                    if (oct_b == '0 || oct_a == oct_b) begin
                        r_state <= S_OCT;
                    end else begin
                        r_state <= S_ROT;
                    end
                end
                S_ROT: begin
                    r_iter <= r_iter + ITER_W'(1);
                    if (r_iter == ITER_LAST) begin
                        r_state <= S_OCT;
                    end
                end
                S_OCT: r_state <= S_QUAD;
                S_QUAD: begin
                    if (r_job == JOB_HEADING) begin
                        r_job   <= JOB_TARGET;
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_SQX;
                    end
                end
                S_SQX: r_state <= S_SQY;
                S_SQY: r_state <= S_ROOT;
                S_ROOT: begin
                    if (r_bit[0]) begin
                        if (r_job == JOB_TARGET) begin
                            r_job   <= JOB_HOME;
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_hx <= cx;
            r_hy <= cy;
            r_bx <= mid_x[CB:1];
            r_by <= mid_y[CB:1];
        end

        unique case (r_state)
            S_LOAD: begin
                r_ax_neg <= vec_x[VW-1];
                r_ay_neg <= vec_y[VW-1];
                r_u      <= abs_y[CB-1:0];
                r_v      <= abs_x[CB-1:0];
            end
            S_PREP: begin
                r_swap <= swap;
                r_zero <= (r_u == '0) && (r_v == '0);
                r_b0   <= (oct_b == '0);
                r_beq  <= (oct_a == oct_b);
                r_x    <= $signed({3'b000, oct_a, {PRESHIFT{1'b0}}});
                r_y    <= $signed({3'b000, oct_b, {PRESHIFT{1'b0}}});
                r_z    <= '0;
            end
            S_ROT: begin
                if (!r_y[XW-1]) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + atan_q16(r_iter);
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - atan_q16(r_iter);
                end
            end
            S_OCT: r_t <= t_fold;
            S_QUAD: begin
                unique case (r_job)
                    JOB_HEADING: r_heading <= angle;
                    JOB_TARGET:  r_ang_t   <= angle;
                    JOB_HOME:    r_ang_h   <= angle;
                    default: ;
                endcase
            end
            S_SQX: r_n <= NW'(sq);
            S_SQY: begin
                r_n    <= r_n + NW'(sq);
                r_root <= '0;
                r_bit  <= NW'({1'b1, {(2 * CB){1'b0}}});
            end
            S_ROOT: begin
                r_n    <= n_n;
                r_root <= n_root;
                r_bit  <= r_bit >> 2;
                if (r_bit[0]) begin
                    if (r_job == JOB_TARGET) begin
                        r_dist_t <= root_dist;
                    end else begin
                        r_dist_h <= root_dist;
                    end
                end
            end
            default: ;
        endcase

        if (out_load) begin
            r_o_heading <= r_heading;
            r_o_tb      <= tb;
            r_o_hb      <= hb;
            r_o_td      <= r_dist_t;
            r_o_hd      <= r_dist_h;
            r_o_tao     <= (atb > $signed({1'b0, r_ang_tol}));
            r_o_hao     <= (ahb > $signed({1'b0, r_ang_tol}));
            r_o_tf      <= (r_dist_t > r_dist_tol);
            r_o_hf      <= (r_dist_h > r_dist_tol);
        end
    end

    assign o_valid            = r_out_valid;
    assign o_heading          = r_o_heading;
    assign o_target_bearing   = r_o_tb;
    assign o_target_distance  = r_o_td;
    assign o_home_bearing     = r_o_hb;
    assign o_home_distance    = r_o_hd;
    assign o_target_angle_off = r_o_tao;
    assign o_target_far       = r_o_tf;
    assign o_home_angle_off   = r_o_hao;
    assign o_home_far         = r_o_hf;

    a_iter_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT && r_iter != ITER_LAST) |=> (r_iter == $past(r_iter) + ITER_W'(1)))
        else $error("CORDIC step counter did not advance");

    a_x_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT) |-> !r_x[XW-1])
        else $error("CORDIC x went negative during vectoring");

    a_root_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT) |-> $onehot(r_bit))
        else $error("Root trial bit is not a single bit");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_valid && r_state == S_IDLE))
        else $error("Finished result was not placed in the output register");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_heading <= ANGLE_W'(359)))
        else $error("Heading outside of a full turn");

endmodule

@@ test/marker_bearing_range_unit_tb.sv @@
// Self-checking testbench for the marker bearing and range unit, with randomized marker frames.
module marker_bearing_range_unit_tb;
    import mbru_pkg::*;

    localparam int COORD_BITS = 12;
    localparam int COORD_MAX = (1 << COORD_BITS) - 1;
    localparam longint Q16 = 65536;
    localparam int SETTLE = 120;
    localparam int LONG_HOLD = 400;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 240;
    localparam int PRINT_CAP = 30;

    localparam longint ATAN_STEP [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    typedef struct {
        logic [MARKER_W-1:0] marker;
        logic [RECT_W-1:0] x;
        logic [RECT_W-1:0] y;
        logic [RECT_W-1:0] w;
        logic [RECT_W-1:0] h;
    } marker_req_t;

    typedef struct {
        logic [ANGLE_W-1:0] heading;
        logic signed [BEAR_W-1:0] target_bearing;
        logic [DIST_W-1:0] target_distance;
        logic signed [BEAR_W-1:0] home_bearing;
        logic [DIST_W-1:0] home_distance;
        logic target_angle_off;
        logic target_far;
        logic home_angle_off;
        logic home_far;
    } nav_report_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic [MARKER_W-1:0] i_marker = '0;
    logic [RECT_W-1:0] i_rect_x = '0;
    logic [RECT_W-1:0] i_rect_y = '0;
    logic [RECT_W-1:0] i_rect_width = '0;
    logic [RECT_W-1:0] i_rect_height = '0;
    logic i_stall = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic o_stall;
    logic o_valid;
    logic [ANGLE_W-1:0] o_heading;
    logic signed [BEAR_W-1:0] o_target_bearing;
    logic [DIST_W-1:0] o_target_distance;
    logic signed [BEAR_W-1:0] o_home_bearing;
    logic [DIST_W-1:0] o_home_distance;
    logic o_target_angle_off;
    logic o_target_far;
    logic o_home_angle_off;
    logic o_home_far;

    marker_req_t marker_queue[$];
    nav_report_t frame_reports[$];

    logic [RECT_W-1:0] centre_x [3];
    logic [RECT_W-1:0] centre_y [3];
    logic [ANGLE_W-1:0] angle_limit = ANGLE_TOL_RESET;
    logic [DIST_W-1:0] distance_limit = DIST_TOL_RESET;

    int unsigned send_wait = 0;
    int unsigned rx_wait = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    logic rx_hold = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned requests_queued = 0;
    int unsigned requests_taken = 0;
    int unsigned results_checked = 0;
    int unsigned settings_used = 1;

    marker_bearing_range_unit #(
        .COORD_BITS(COORD_BITS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_marker(i_marker),
        .i_rect_x(i_rect_x),
        .i_rect_y(i_rect_y),
        .i_rect_width(i_rect_width),
        .i_rect_height(i_rect_height),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_heading(o_heading),
        .o_target_bearing(o_target_bearing),
        .o_target_distance(o_target_distance),
        .o_home_bearing(o_home_bearing),
        .o_home_distance(o_home_distance),
        .o_target_angle_off(o_target_angle_off),
        .o_target_far(o_target_far),
        .o_home_angle_off(o_home_angle_off),
        .o_home_far(o_home_far),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [RECT_W-1:0] rect_centre(logic [RECT_W-1:0] pos,
                                                      logic [RECT_W-1:0] size);
        int unsigned sum;
        sum = pos + (size >> 1);
        return (sum > COORD_MAX) ? RECT_W'(COORD_MAX) : sum[RECT_W-1:0];
    endfunction

    // Angle of (a, b) with 0 <= b <= a, in 2^-16 degree, by vectoring rotations.
    function automatic longint octant_q16(longint a, longint b);
        longint x, y, z, xs, ys;
        if (b == 0) return 0;
        if (b == a) return 45 * Q16;
        x = a <<< 16;
        y = b <<< 16;
        z = 0;
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[i];
            end
        end
        if (z < 1) z = 1;
        if (z > 45 * Q16 - 1) z = 45 * Q16 - 1;
        return z;
    endfunction

    // Whole degrees of the direction (ax, ay), measured from +y toward +x, in 0..359.
    function automatic int bearing_deg(longint ax, longint ay);
        longint u, v, t, phi;
        u = (ay < 0) ? -ay : ay;
        v = (ax < 0) ? -ax : ax;
        if (u == 0 && v == 0) return 0;
        if (v <= u) t = octant_q16(u, v);
        else t = 90 * Q16 - octant_q16(v, u);
        if (ay >= 0 && ax >= 0) phi = t;
        else if (ay < 0 && ax >= 0) phi = 180 * Q16 - t;
        else if (ay < 0) phi = 180 * Q16 + t;
        else phi = 360 * Q16 - t;
        return int'(phi >>> 16);
    endfunction

    function automatic logic [DIST_W-1:0] floor_length(longint dx, longint dy);
        longint unsigned n, root, probe;
        n = dx * dx + dy * dy;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > n) probe = probe >> 2;
        while (probe != 0) begin
            if (n >= root + probe) begin
                n = n - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return (root > DIST_MAX) ? DIST_MAX : root[DIST_W-1:0];
    endfunction

    task automatic predict_request(marker_req_t req);
        logic [RECT_W-1:0] cx, cy;
        longint mx, my, tx, ty;
        int heading, tb, hb;
        nav_report_t rpt;
        cx = rect_centre(req.x, req.w);
        cy = rect_centre(req.y, req.h);
        if (req.marker != MK_HOME) begin
            centre_x[req.marker] = cx;
            centre_y[req.marker] = cy;
            return;
        end
        mx = (longint'(centre_x[MK_FRONT]) + longint'(centre_x[MK_REAR])) / 2;
        my = (longint'(centre_y[MK_FRONT]) + longint'(centre_y[MK_REAR])) / 2;
        tx = longint'(centre_x[MK_TARGET]) - mx;
        ty = longint'(centre_y[MK_TARGET]) - my;
        heading = bearing_deg(longint'(centre_x[MK_FRONT]) - longint'(centre_x[MK_REAR]),
                              longint'(centre_y[MK_FRONT]) - longint'(centre_y[MK_REAR]));
        tb = bearing_deg(tx, ty) - heading;
        hb = bearing_deg(longint'(cx) - mx, longint'(cy) - my) - heading;
        rpt.heading = heading[ANGLE_W-1:0];
        rpt.target_bearing = tb[BEAR_W-1:0];
        rpt.target_distance = floor_length(tx, ty);
        rpt.home_bearing = hb[BEAR_W-1:0];
        rpt.home_distance = floor_length(longint'(cx) - mx, longint'(cy) - my);
        rpt.target_angle_off = ((tb < 0) ? -tb : tb) > int'(angle_limit);
        rpt.target_far = rpt.target_distance > distance_limit;
        rpt.home_angle_off = ((hb < 0) ? -hb : hb) > int'(angle_limit);
        rpt.home_far = rpt.home_distance > distance_limit;
        frame_reports.push_back(rpt);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    task automatic check_report();
        nav_report_t want;
        if (frame_reports.size() == 0) begin
            report_mismatch("result with no home request", 1, 0);
            return;
        end
        want = frame_reports.pop_front();
        if (o_heading !== want.heading)
            report_mismatch("heading", o_heading, want.heading);
        if (o_target_bearing !== want.target_bearing)
            report_mismatch("target_bearing", o_target_bearing, want.target_bearing);
        if (o_target_distance !== want.target_distance)
            report_mismatch("target_distance", o_target_distance, want.target_distance);
        if (o_home_bearing !== want.home_bearing)
            report_mismatch("home_bearing", o_home_bearing, want.home_bearing);
        if (o_home_distance !== want.home_distance)
            report_mismatch("home_distance", o_home_distance, want.home_distance);
        if (o_target_angle_off !== want.target_angle_off)
            report_mismatch("target_angle_off", o_target_angle_off, want.target_angle_off);
        if (o_target_far !== want.target_far)
            report_mismatch("target_far", o_target_far, want.target_far);
        if (o_home_angle_off !== want.home_angle_off)
            report_mismatch("home_angle_off", o_home_angle_off, want.home_angle_off);
        if (o_home_far !== want.home_far)
            report_mismatch("home_far", o_home_far, want.home_far);
    endtask

    function automatic int unsigned draw_wait(bit calm);
        if (calm || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 15);
    endfunction

    // Request driver.
    always @(posedge i_clk) begin
        marker_req_t req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                req.marker = i_marker;
                req.x = i_rect_x;
                req.y = i_rect_y;
                req.w = i_rect_width;
                req.h = i_rect_height;
                predict_request(req);
                requests_taken++;
                send_wait = draw_wait(tx_calm);
            end
            if (!i_valid || !o_stall) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_valid <= 1'b0;
                end else if (marker_queue.size() != 0) begin
                    req = marker_queue.pop_front();
                    i_valid <= 1'b1;
                    i_marker <= req.marker;
                    i_rect_x <= req.x;
                    i_rect_y <= req.y;
                    i_rect_width <= req.w;
                    i_rect_height <= req.h;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                check_report();
                results_checked++;
                rx_wait = draw_wait(rx_calm);
            end else if (o_valid && rx_wait > 0) begin
                rx_wait--;
            end
            i_stall <= rx_hold || (rx_wait > 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_request(logic [MARKER_W-1:0] mk, int unsigned x, int unsigned y,
                                int unsigned w, int unsigned h);
        marker_req_t req;
        req.marker = mk;
        req.x = x[RECT_W-1:0];
        req.y = y[RECT_W-1:0];
        req.w = w[RECT_W-1:0];
        req.h = h[RECT_W-1:0];
        marker_queue.push_back(req);
        requests_queued++;
    endtask

    function automatic marker_req_t random_rect(logic [MARKER_W-1:0] mk, int unsigned span,
                                                int unsigned bx, int unsigned by);
        marker_req_t req;
        int unsigned sx, sy;
        sx = bx + $urandom_range(0, span - 1);
        sy = by + $urandom_range(0, span - 1);
        req.marker = mk;
        req.x = sx[RECT_W-1:0];
        req.y = sy[RECT_W-1:0];
        if ($urandom_range(0, 7) == 0) begin
            req.w = '0;
            req.h = '0;
        end else if ($urandom_range(0, 15) == 0) begin
            req.w = RECT_W'($urandom_range(0, 4095));
            req.h = RECT_W'($urandom_range(0, 4095));
        end else begin
            req.w = RECT_W'($urandom_range(0, span));
            req.h = RECT_W'($urandom_range(0, span));
        end
        return req;
    endfunction

    // One camera frame: front, rear and target in shuffled order, each included at random, then home.
    task automatic queue_frame();
        marker_req_t rects [3];
        marker_req_t req;
        logic [MARKER_W-1:0] seq [3];
        logic [MARKER_W-1:0] swap;
        int unsigned span, bx, by, j, d;
        int dx, dy;
        case ($urandom_range(0, 3))
            0: span = 16;
            1: span = 128;
            2: span = 1024;
            default: span = 4096;
        endcase
        bx = $urandom_range(0, 4096 - span);
        by = $urandom_range(0, 4096 - span);
        rects[MK_FRONT] = random_rect(MK_FRONT, span, bx, by);
        rects[MK_REAR] = random_rect(MK_REAR, span, bx, by);
        rects[MK_TARGET] = random_rect(MK_TARGET, span, bx, by);
        // Axis-aligned and diagonal bots hit the exact octant boundaries.
        if ($urandom_range(0, 5) == 0) begin
            d = $urandom_range(1, span);
            dx = $urandom_range(0, 2) - 1;
            dy = $urandom_range(0, 2) - 1;
            rects[MK_REAR] = rects[MK_FRONT];
            rects[MK_REAR].marker = MK_REAR;
            rects[MK_REAR].x = rects[MK_FRONT].x + RECT_W'(dx * int'(d));
            rects[MK_REAR].y = rects[MK_FRONT].y + RECT_W'(dy * int'(d));
        end
        seq[0] = MK_FRONT;
        seq[1] = MK_REAR;
        seq[2] = MK_TARGET;
        for (int k = 2; k > 0; k--) begin
            j = $urandom_range(0, k);
            swap = seq[k];
            seq[k] = seq[j];
            seq[j] = swap;
        end
        for (int k = 0; k < 3; k++) begin
            if ($urandom_range(0, 11) != 0) begin
                req = rects[seq[k]];
                push_request(req.marker, req.x, req.y, req.w, req.h);
            end
        end
        req = random_rect(MK_HOME, span, bx, by);
        push_request(req.marker, req.x, req.y, req.w, req.h);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (marker_queue.size() != 0 || i_valid || frame_reports.size() != 0);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_ANGLE_TOL) angle_limit = value[ANGLE_W-1:0];
        else distance_limit = value[DIST_W-1:0];
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] angle_plan [7];
        logic [CFG_DATA_W-1:0] dist_plan [7];
        marker_req_t req;
        int unsigned budget;
        bit paused;
        for (int k = 0; k < 3; k++) begin
            centre_x[k] = '0;
            centre_y[k] = '0;
        end
        angle_plan = '{13'd0, 13'd359, 13'h1E07, 13'd45, 13'd0, 13'd5, 13'h1FFF};
        dist_plan = '{13'd0, 13'd5792, 13'h1FFF, 13'd20, 13'd0, 13'd300, 13'd1};
        angle_plan[4] = CFG_DATA_W'($urandom_range(0, 8191));
        dist_plan[4] = CFG_DATA_W'($urandom_range(0, 8191));
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset tolerances.
        push_request(MK_HOME, 0, 0, 0, 0);
        push_request(MK_FRONT, 100, 100, 0, 0);
        push_request(MK_REAR, 100, 200, 0, 0);
        push_request(MK_TARGET, 100, 20, 0, 0);
        push_request(MK_HOME, 100, 150, 10, 10);
        push_request(MK_FRONT, 4095, 4095, 4095, 4095);
        push_request(MK_REAR, 0, 0, 4095, 4095);
        push_request(MK_TARGET, 0, 4095, 0, 0);
        push_request(MK_HOME, 4095, 0, 4095, 4095);
        push_request(MK_FRONT, 300, 200, 0, 0);
        push_request(MK_REAR, 200, 200, 0, 0);
        push_request(MK_TARGET, 200, 200, 0, 0);
        push_request(MK_HOME, 250, 200, 0, 0);
        push_request(MK_FRONT, 100, 300, 0, 0);
        push_request(MK_REAR, 200, 200, 0, 0);
        push_request(MK_TARGET, 0, 0, 0, 0);
        push_request(MK_HOME, 4095, 4095, 0, 0);
        push_request(MK_FRONT, 500, 500, 8, 8);
        push_request(MK_REAR, 500, 500, 8, 8);
        push_request(MK_HOME, 506, 520, 4, 4);
        push_request(MK_TARGET, 0, 0, 1, 1);
        push_request(MK_HOME, 4094, 4094, 3, 3);

        for (int p = 0; p < 7; p++) begin
            wait_drained();
            repeat (SETTLE) @(posedge i_clk);
            write_register(REG_ANGLE_TOL, angle_plan[p]);
            write_register(REG_DIST_TOL, dist_plan[p]);
            settings_used++;
            tx_calm = (p == 2) || (p == 4);
            rx_calm = (p == 4);
            paused = 1'b0;
            // The receiver holds off while the sender keeps offering frames.
            if (p == 2) begin
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (LONG_HOLD) @(posedge i_clk);
                        rx_hold <= 1'b0;
                    end
                join_none
            end
            budget = requests_queued + PHASE_ITEMS;
            while (requests_queued < budget) begin
                if (p == 5 && !paused && requests_queued + PHASE_ITEMS / 2 >= budget) begin
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 9) == 0) begin
                    req = random_rect(MARKER_W'($urandom_range(0, 3)), 4096, 0, 0);
                    push_request(req.marker, req.x, req.y, req.w, req.h);
                end else begin
                    queue_frame();
                end
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        $display("Summary: %0d marker requests taken, %0d frame results checked, %0d mismatches.",
                 requests_taken, results_checked, mismatches);
        $display("Covered %0d tolerance settings, zero vectors, saturated centres and back-pressure.",
                 settings_used);
        if (mismatches == 0 && frame_reports.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/mbru_pkg.sv
design/marker_bearing_range_unit.sv
test/marker_bearing_range_unit_tb.sv
